// ===== src/irpt_pkg.sv =====
// ============================================================================
// irpt_pkg: shared types and constants of the IR pulse train transmitter
// Phase encoding, result record, reset values of the configuration registers
// and the character codes used by the duration parser.
// ============================================================================
package irpt_pkg;

    localparam int MAX_PULSES_DEF  = 256;
    localparam int FIELD_CHARS_DEF = 12;

    localparam logic [10:0] PRESCALE_RESET = 11'd64;
    localparam logic [10:0] PRESCALE_MAX   = 11'd1024;
    localparam logic [15:0] CARRIER_RESET  = 16'd216;

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Configuration register indexes
    localparam logic CFG_PRESCALE = 1'b0;
    localparam logic CFG_CARRIER  = 1'b1;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_LOAD,
        PH_PLAY
    } phase_t;

    typedef struct packed {
        logic done;
        logic transmitting;
        logic emitter_on;
    } result_t;

endpackage

// ===== src/ir_pulse_train_transmitter.sv =====
// ============================================================================
// ir_pulse_train_transmitter: raw infrared pulse train transmitter
// Parses a pulse count and comma-terminated decimal durations from received
// bytes, stores them and plays them as carrier-gated marks and dark spaces.
// ============================================================================
// One input transfer is taken every clock cycle while the result register is
// free or being drained; each transfer is fully processed in that cycle and
// its result appears in the output register on the next cycle. Durations live
// in a one-port-write, one-port-read memory with registered read; the entry
// of the pulse being played is prefetched whenever the play index moves, so
// base clock ticks (s_tuser = 1) can arrive back to back. No clearing pass is
// needed after reset. Configuration writes are always accepted (cfg_ready is
// tied high) and take effect on the next item.
module ir_pulse_train_transmitter #(
    parameter int MAX_PULSES  = irpt_pkg::MAX_PULSES_DEF,
    parameter int FIELD_CHARS = irpt_pkg::FIELD_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] emitter_on, [1] transmitting, [2] done_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic [10:0]       prescale_reg;
    logic [15:0]       carrier_reg;
    logic              m_tvalid_reg;
    irpt_pkg::result_t out_reg;
    irpt_pkg::result_t res;
    logic              item_en;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign item_en   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= irpt_pkg::PRESCALE_RESET;
            carrier_reg  <= irpt_pkg::CARRIER_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == irpt_pkg::CFG_PRESCALE)
            begin
                prescale_reg <= cfg_data[10:0];
            end
            else
            begin
                carrier_reg <= cfg_data;
            end
        end
    end

    irpt_core #(
        .MAX_PULSES  (MAX_PULSES),
        .FIELD_CHARS (FIELD_CHARS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_en  (item_en),
        .mode     (s_tuser),
        .rx_byte  (s_tdata),
        .prescale (prescale_reg),
        .carrier  (carrier_reg),
        .res      (res)
    );

    // hold the result until the downstream side takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (item_en)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_en)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_reg};

endmodule

// ===== src/irpt_dur_mem.sv =====
// ============================================================================
// irpt_dur_mem: pulse duration store
// One write port and one registered read port; a write to the entry being
// read in the same cycle is forwarded into the read data.
// ============================================================================
module irpt_dur_mem #(
    parameter int MAX_PULSES = irpt_pkg::MAX_PULSES_DEF,
    parameter int IDX_W      = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [15:0]      wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [15:0]      rd_data
);

    logic [15:0] mem [MAX_PULSES];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/irpt_core.sv =====
// ============================================================================
// irpt_core: parser and playback sequencer
// Holds the phase, parser and playback counters, writes parsed durations
// into the store and reads back the duration of the pulse being played.
// ============================================================================
module irpt_core #(
    parameter int MAX_PULSES  = irpt_pkg::MAX_PULSES_DEF,
    parameter int FIELD_CHARS = irpt_pkg::FIELD_CHARS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_en,
    input  logic               mode,
    input  logic [7:0]         rx_byte,
    input  logic [10:0]        prescale,
    input  logic [15:0]        carrier,
    output irpt_pkg::result_t  res
);

    localparam int CNT_W  = $clog2(MAX_PULSES + 1);
    localparam int IDX_W  = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;
    localparam int CHAR_W = $clog2(FIELD_CHARS + 1);

    irpt_pkg::phase_t phase_reg, phase_next;
    logic [CNT_W-1:0]  pulse_cnt_reg, pulse_cnt_next;
    logic [CNT_W-1:0]  load_idx_reg, load_idx_next;
    logic [CHAR_W-1:0] char_cnt_reg, char_cnt_next;
    logic [15:0]       field_reg, field_next;
    logic              stopped_reg, stopped_next;
    logic [CNT_W-1:0]  play_idx_reg, play_idx_next;
    logic [15:0]       dur_cnt_reg, dur_cnt_next;
    logic [9:0]        pre_cnt_reg, pre_cnt_next;
    logic [15:0]       car_cnt_reg, car_cnt_next;
    logic              emit_reg, emit_next;

    logic              wr_en;
    logic [15:0]       dur_q;
    logic [8:0]        cnt_sat;
    logic [CNT_W:0]    load_inc;
    logic [CNT_W:0]    play_inc;
    logic [10:0]       pre_eff;
    logic [15:0]       car_eff;
    logic [10:0]       pre_inc;
    logic [16:0]       car_inc;
    logic              done;

    irpt_dur_mem #(
        .MAX_PULSES (MAX_PULSES),
        .IDX_W      (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (load_idx_reg[IDX_W-1:0]),
        .wr_data (field_reg),
        .rd_addr (play_idx_next[IDX_W-1:0]),
        .rd_data (dur_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= irpt_pkg::PH_WAIT;
            pulse_cnt_reg <= '0;
            load_idx_reg  <= '0;
            char_cnt_reg  <= '0;
            field_reg     <= '0;
            stopped_reg   <= 1'b0;
            play_idx_reg  <= '0;
            dur_cnt_reg   <= '0;
            pre_cnt_reg   <= '0;
            car_cnt_reg   <= '0;
            emit_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pulse_cnt_reg <= pulse_cnt_next;
            load_idx_reg  <= load_idx_next;
            char_cnt_reg  <= char_cnt_next;
            field_reg     <= field_next;
            stopped_reg   <= stopped_next;
            play_idx_reg  <= play_idx_next;
            dur_cnt_reg   <= dur_cnt_next;
            pre_cnt_reg   <= pre_cnt_next;
            car_cnt_reg   <= car_cnt_next;
            emit_reg      <= emit_next;
        end
    end

    always_comb
    begin
        pre_eff = prescale;
        if (prescale == 11'd0)
        begin
            pre_eff = 11'd1;
        end
        else if (prescale > irpt_pkg::PRESCALE_MAX)
        begin
            pre_eff = irpt_pkg::PRESCALE_MAX;
        end
        car_eff = (carrier == 16'd0) ? 16'd1 : carrier;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        pulse_cnt_next = pulse_cnt_reg;
        load_idx_next  = load_idx_reg;
        char_cnt_next  = char_cnt_reg;
        field_next     = field_reg;
        stopped_next   = stopped_reg;
        play_idx_next  = play_idx_reg;
        dur_cnt_next   = dur_cnt_reg;
        pre_cnt_next   = pre_cnt_reg;
        car_cnt_next   = car_cnt_reg;
        emit_next      = emit_reg;
        wr_en          = 1'b0;
        done           = 1'b0;

        cnt_sat  = ({1'b0, rx_byte} > 9'(MAX_PULSES)) ? 9'(MAX_PULSES) : {1'b0, rx_byte};
        load_inc = {1'b0, load_idx_reg} + 1'b1;
        play_inc = {1'b0, play_idx_reg} + 1'b1;
        pre_inc  = {1'b0, pre_cnt_reg} + 11'd1;
        car_inc  = {1'b0, car_cnt_reg} + 17'd1;

        if (item_en)
        begin
            unique case (phase_reg)
                irpt_pkg::PH_LOAD:
                begin
                    if (!mode)
                    begin
                        if ((rx_byte == irpt_pkg::CHAR_COMMA) && (char_cnt_reg != '0))
                        begin
                            // store the field and advance to the next one
                            wr_en         = 1'b1;
                            load_idx_next = load_inc[CNT_W-1:0];
                            char_cnt_next = '0;
                            field_next    = '0;
                            stopped_next  = 1'b0;
                            if (load_inc >= {1'b0, pulse_cnt_reg})
                            begin
                                phase_next    = irpt_pkg::PH_PLAY;
                                play_idx_next = '0;
                                pre_cnt_next  = '0;
                                dur_cnt_next  = '0;
                                car_cnt_next  = '0;
                                emit_next     = 1'b0;
                            end
                        end
                        else if (char_cnt_reg >= CHAR_W'(FIELD_CHARS))
                        begin
                            // overlong field: drop and restart
                            char_cnt_next = '0;
                            field_next    = '0;
                            stopped_next  = 1'b0;
                        end
                        else
                        begin
                            char_cnt_next = char_cnt_reg + 1'b1;
                            if (!stopped_reg && (rx_byte >= irpt_pkg::CHAR_ZERO)
                                && (rx_byte <= irpt_pkg::CHAR_NINE))
                            begin
                                field_next = (field_reg << 3) + (field_reg << 1)
                                             + {12'd0, rx_byte[3:0]};
                            end
                            else
                            begin
                                stopped_next = 1'b1;
                            end
                        end
                    end
                end
                irpt_pkg::PH_PLAY:
                begin
                    if (mode)
                    begin
                        if (!play_idx_reg[0])
                        begin
                            if (car_inc >= {1'b0, car_eff})
                            begin
                                car_cnt_next = '0;
                                emit_next    = ~emit_reg;
                            end
                            else
                            begin
                                car_cnt_next = car_inc[15:0];
                            end
                        end
                        else
                        begin
                            emit_next = 1'b0;
                        end

                        if (pre_inc >= pre_eff)
                        begin
                            pre_cnt_next = '0;
                            if (dur_cnt_reg >= dur_q)
                            begin
                                // pulse over: start the next one dark
                                play_idx_next = play_inc[CNT_W-1:0];
                                dur_cnt_next  = '0;
                                car_cnt_next  = '0;
                                emit_next     = 1'b0;
                                if (play_inc >= {1'b0, pulse_cnt_reg})
                                begin
                                    phase_next = irpt_pkg::PH_WAIT;
                                    done       = 1'b1;
                                end
                            end
                            else
                            begin
                                dur_cnt_next = dur_cnt_reg + 16'd1;
                            end
                        end
                        else
                        begin
                            pre_cnt_next = pre_inc[9:0];
                        end
                    end
                end
                default:
                begin
                    if (!mode)
                    begin
                        pulse_cnt_next = CNT_W'(cnt_sat);
                        load_idx_next  = '0;
                        char_cnt_next  = '0;
                        field_next     = '0;
                        stopped_next   = 1'b0;
                        phase_next     = (cnt_sat == 9'd0) ? irpt_pkg::PH_WAIT
                                                           : irpt_pkg::PH_LOAD;
                    end
                end
            endcase
            if (phase_next != irpt_pkg::PH_PLAY)
            begin
                emit_next = 1'b0;
            end
        end

        res.done         = done;
        res.transmitting = (phase_next == irpt_pkg::PH_PLAY);
        res.emitter_on   = emit_next;
    end

`ifndef ASSERT_OFF
    a_done_ends_play: assert property (@(posedge clk) disable iff (!rst_n)
        (item_en && res.done) |=> (phase_reg == irpt_pkg::PH_WAIT))
        else $error("done without return to wait");

    a_dark_off_play: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != irpt_pkg::PH_PLAY) |-> !emit_reg)
        else $error("emitter lit outside playback");

    a_load_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == irpt_pkg::PH_LOAD) |-> (load_idx_reg < pulse_cnt_reg))
        else $error("load index past pulse count");

    a_play_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == irpt_pkg::PH_PLAY) |-> (play_idx_reg < pulse_cnt_reg))
        else $error("play index past pulse count");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !item_en |=> $stable(phase_reg) && $stable(play_idx_reg))
        else $error("state moved without an item");
`endif

endmodule

// ===== bench/irpt_checker.sv =====
// ============================================================================
// irpt_checker: result checker for the IR pulse train transmitter
// Watches the input, configuration and result channels, keeps its own copy
// of the parser and playback state, predicts one result per input transfer
// and compares every result transfer field by field with the oldest one.
// ============================================================================
module irpt_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] mode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [0] emitter_on, [1] transmitting, [2] done_res
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [10:0] prescale_reg;
    logic [15:0] carrier_reg;

    irpt_pkg::phase_t phase;
    logic [8:0]  total_pulses;
    logic [8:0]  stored;
    logic [15:0] stash [irpt_pkg::MAX_PULSES_DEF];
    logic [3:0]  chars;
    logic [15:0] value;
    logic        stopped;
    logic [8:0]  played;
    logic [16:0] units;
    logic [10:0] sub_ticks;
    logic [16:0] carrier_ticks;
    logic        lit;

    irpt_pkg::result_t level_queue [$];
    irpt_pkg::result_t want;
    irpt_pkg::result_t got;
    irpt_pkg::result_t next_level;
    int      fault_count = 0;

    task automatic clear_field();
        chars   = '0;
        value   = '0;
        stopped = 1'b0;
    endtask

    task automatic start_pulse();
        units         = '0;
        carrier_ticks = '0;
        lit           = 1'b0;
    endtask

    // Apply one input item to the local state and return the level it leaves.
    task automatic step_transmitter(input logic mode, input logic [7:0] b,
                                    output irpt_pkg::result_t r);
        logic        finished;
        logic [10:0] eff_pre;
        logic [16:0] eff_car;
        finished = 1'b0;
        if (!mode)
        begin
            if (phase == irpt_pkg::PH_WAIT)
            begin
                total_pulses = {1'b0, b};
                stored       = '0;
                clear_field();
                phase = (b == 8'd0) ? irpt_pkg::PH_WAIT : irpt_pkg::PH_LOAD;
            end
            else if (phase == irpt_pkg::PH_LOAD)
            begin
                if (b == irpt_pkg::CHAR_COMMA && chars != 0)
                begin
                    stash[stored[7:0]] = value;
                    stored = stored + 9'd1;
                    clear_field();
                    if (stored >= total_pulses)
                    begin
                        phase     = irpt_pkg::PH_PLAY;
                        played    = '0;
                        sub_ticks = '0;
                        start_pulse();
                    end
                end
                else if (chars >= irpt_pkg::FIELD_CHARS_DEF)
                begin
                    // overlong field: drop the character and restart
                    clear_field();
                end
                else
                begin
                    chars = chars + 4'd1;
                    if (!stopped && b >= irpt_pkg::CHAR_ZERO && b <= irpt_pkg::CHAR_NINE)
                        value = value * 16'd10 + 16'(b - irpt_pkg::CHAR_ZERO);
                    else
                        stopped = 1'b1;
                end
            end
        end
        else if (phase == irpt_pkg::PH_PLAY)
        begin
            eff_pre = (prescale_reg == 0) ? 11'd1 :
                      (prescale_reg > irpt_pkg::PRESCALE_MAX) ? irpt_pkg::PRESCALE_MAX
                                                              : prescale_reg;
            eff_car = (carrier_reg == 0) ? 17'd1 : {1'b0, carrier_reg};
            if (!played[0])
            begin
                carrier_ticks = carrier_ticks + 17'd1;
                if (carrier_ticks >= eff_car)
                begin
                    carrier_ticks = '0;
                    lit = ~lit;
                end
            end
            else
            begin
                lit = 1'b0;
            end
            sub_ticks = sub_ticks + 11'd1;
            if (sub_ticks >= eff_pre)
            begin
                sub_ticks = '0;
                units = units + 17'd1;
                if (units >= {1'b0, stash[played[7:0]]} + 17'd1)
                begin
                    played = played + 9'd1;
                    start_pulse();
                    if (played >= total_pulses)
                    begin
                        phase    = irpt_pkg::PH_WAIT;
                        finished = 1'b1;
                    end
                end
            end
        end
        if (phase != irpt_pkg::PH_PLAY)
            lit = 1'b0;
        r.emitter_on   = lit;
        r.transmitting = (phase == irpt_pkg::PH_PLAY);
        r.done         = finished;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg = irpt_pkg::PRESCALE_RESET;
            carrier_reg  = irpt_pkg::CARRIER_RESET;
            phase        = irpt_pkg::PH_WAIT;
            total_pulses = '0;
            stored       = '0;
            clear_field();
            played       = '0;
            sub_ticks    = '0;
            start_pulse();
            level_queue.delete();
            outstanding <= 0;
            errors      <= fault_count;
        end
        else
        begin
            // compare first so a stray result cannot match this cycle's item
            if (m_tvalid && m_tready)
            begin
                if (level_queue.size() == 0)
                begin
                    fault_count++;
                    $display("%0t: result with nothing pending, expected none, got %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = level_queue.pop_front();
                    got  = irpt_pkg::result_t'(m_tdata[2:0]);
                    if (got.emitter_on !== want.emitter_on)
                    begin
                        fault_count++;
                        $display("%0t: emitter_on expected %0b got %0b",
                                 $time, want.emitter_on, got.emitter_on);
                    end
                    if (got.transmitting !== want.transmitting)
                    begin
                        fault_count++;
                        $display("%0t: transmitting expected %0b got %0b",
                                 $time, want.transmitting, got.transmitting);
                    end
                    if (got.done !== want.done)
                    begin
                        fault_count++;
                        $display("%0t: done_res expected %0b got %0b",
                                 $time, want.done, got.done);
                    end
                    if (m_tdata[7:3] !== 5'd0)
                    begin
                        fault_count++;
                        $display("%0t: tdata padding expected 00 got %h",
                                 $time, m_tdata[7:3]);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                step_transmitter(s_tuser, s_tdata, next_level);
                level_queue.push_back(next_level);
            end
            // a register write applies from the next item on
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == irpt_pkg::CFG_PRESCALE)
                    prescale_reg = cfg_data[10:0];
                else
                    carrier_reg = cfg_data;
            end
            outstanding <= level_queue.size();
            errors      <= fault_count;
        end
    end

endmodule

// ===== bench/testbench.sv =====
// ============================================================================
// testbench: top level bench for the IR pulse train transmitter
// Loads pulse counts and decimal durations, plays them out with base clock
// ticks under several prescale and carrier settings, with random gaps on the
// input side and random stalls on the result side; the checker grades results.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 2000;
    localparam int ITEM_TARGET  = 1600;
    localparam int HOLD_AT_ITEM = 300;
    localparam int HOLD_CYCLES  = 400;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] rx_byte
    logic        s_tuser;   // [0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [0] emitter_on, [1] transmitting, [2] done_res
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    int   errors;
    int   outstanding;
    int   items_sent = 0;
    int   burst_left = 0;
    int   quiet = 0;
    int   cur_pre = 64;
    int   phase_no;
    bit   long_hold_done = 1'b0;

    ir_pulse_train_transmitter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    irpt_checker monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #10 clk = ~clk;

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: stall patterns of random length, plus one long hold-off.
    initial
    begin
        int seg;
        int style;
        m_tready = 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (!long_hold_done && items_sent >= HOLD_AT_ITEM)
            begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                seg   = $urandom_range(10, 60);
                style = $urandom_range(0, 2);
                repeat (seg)
                begin
                    case (style)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= ($urandom_range(0, 3) != 0);
                        default: m_tready <= 1'($urandom_range(0, 1));
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    function automatic logic [7:0] stray_char(input bit allow_digit);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == irpt_pkg::CHAR_COMMA
               || (!allow_digit && b >= irpt_pkg::CHAR_ZERO && b <= irpt_pkg::CHAR_NINE));
        return b;
    endfunction

    // Offer one item in bursts with random gaps; return once it is transferred.
    task automatic offer(input logic mode, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Field character, now and then preceded by a tick that the parser ignores.
    task automatic send_char(input logic [7:0] c);
        if ($urandom_range(0, 7) == 0)
            offer(1'b1, 8'($urandom_range(0, 255)));
        offer(1'b0, c);
    endtask

    // Send one duration field; val is the duration it stores.
    task automatic send_field(input int maxd, output int val);
        int kind;
        int d;
        kind = $urandom_range(0, 9);
        d    = $urandom_range(0, maxd);
        val  = d;
        case (kind)
            6:
            begin
                // wraps past 65535 back to a small value
                send_char(8'(irpt_pkg::CHAR_ZERO + 6));
                send_char(8'(irpt_pkg::CHAR_ZERO + 5));
                send_char(8'(irpt_pkg::CHAR_ZERO + 5));
                send_char(8'(irpt_pkg::CHAR_ZERO + 3));
                send_char(8'(irpt_pkg::CHAR_ZERO + 6 + d));
            end
            7:
            begin
                send_char(8'(irpt_pkg::CHAR_ZERO + d));
                send_char(stray_char(1'b0));
                repeat ($urandom_range(0, 4)) send_char(stray_char(1'b1));
            end
            8:
            begin
                // overflow the field, then restart it with a clean value
                repeat (irpt_pkg::FIELD_CHARS_DEF + 1) send_char(stray_char(1'b1));
                send_char(8'(irpt_pkg::CHAR_ZERO + d));
            end
            9:
            begin
                send_char(irpt_pkg::CHAR_COMMA);
                if ($urandom_range(0, 1) != 0)
                    send_char(8'(irpt_pkg::CHAR_ZERO + d));
                val = 0;
            end
            default:
            begin
                repeat ($urandom_range(0, 2)) send_char(irpt_pkg::CHAR_ZERO);
                send_char(8'(irpt_pkg::CHAR_ZERO + d));
            end
        endcase
        send_char(irpt_pkg::CHAR_COMMA);
    endtask

    // Ticks for a whole pulse train, with ignored bytes mixed in before the end.
    task automatic play_ticks(input int total);
        for (int i = 0; i < total; i++)
        begin
            offer(1'b1, 8'($urandom_range(0, 255)));
            if (i < total - 1 && $urandom_range(0, 15) == 0)
                offer(1'b0, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_frame(input int n, input int maxd);
        int units;
        int val;
        units = 0;
        offer(1'b0, 8'(n));
        for (int i = 0; i < n; i++)
        begin
            send_field(maxd, val);
            units += val + 1;
        end
        play_ticks(units * cur_pre);
        if ($urandom_range(0, 3) == 0)
            offer(1'b1, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 5) == 0)
            offer(1'b0, 8'd0);
    endtask

    // Hold the input until every result is back, then let the pipeline empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [10:0] pre, input logic [15:0] car);
        write_reg(irpt_pkg::CFG_PRESCALE, {5'd0, pre});
        write_reg(irpt_pkg::CFG_CARRIER, car);
        cfg_valid <= 1'b0;
        cur_pre = (pre == 0) ? 1 :
                  (pre > irpt_pkg::PRESCALE_MAX) ? int'(irpt_pkg::PRESCALE_MAX) : int'(pre);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = irpt_pkg::CFG_PRESCALE;
        cfg_data  = 16'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle noise, empty count, one pulse at the reset settings.
        offer(1'b1, 8'hFF);
        offer(1'b0, 8'd0);
        offer(1'b0, 8'd1);
        offer(1'b0, irpt_pkg::CHAR_ZERO);
        offer(1'b0, irpt_pkg::CHAR_COMMA);
        play_ticks(64);
        settle();

        // Directed: empty-field comma, wrapped value, digits stopped by a non-digit.
        set_config(11'd1, 16'd1);
        offer(1'b0, 8'd3);
        offer(1'b0, irpt_pkg::CHAR_COMMA);
        offer(1'b0, irpt_pkg::CHAR_COMMA);
        offer(1'b0, 8'(irpt_pkg::CHAR_ZERO + 6));
        offer(1'b0, 8'(irpt_pkg::CHAR_ZERO + 5));
        offer(1'b0, 8'(irpt_pkg::CHAR_ZERO + 5));
        offer(1'b0, 8'(irpt_pkg::CHAR_ZERO + 3));
        offer(1'b0, 8'(irpt_pkg::CHAR_ZERO + 7));
        offer(1'b0, irpt_pkg::CHAR_COMMA);
        offer(1'b0, 8'(irpt_pkg::CHAR_ZERO + 2));
        offer(1'b0, 8'hFF);
        offer(1'b0, 8'(irpt_pkg::CHAR_ZERO + 7));
        offer(1'b0, irpt_pkg::CHAR_COMMA);
        play_ticks(6);
        settle();

        phase_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (phase_no)
                0:
                begin
                    // prescale above the limit runs at the limit
                    set_config(11'h7FF, 16'hFFFF);
                    send_frame(1, 0);
                end
                1:
                begin
                    set_config(11'd0, 16'd0);
                    send_frame(40, 0);
                end
                default:
                begin
                    set_config(11'($urandom_range(0, 4)), 16'($urandom_range(0, 6)));
                    repeat ($urandom_range(3, 8))
                        send_frame($urandom_range(1, 6), 3);
                end
            endcase
            settle();
            phase_no++;
        end

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/irpt_pkg.sv
src/irpt_dur_mem.sv
src/irpt_core.sv
src/ir_pulse_train_transmitter.sv
bench/irpt_checker.sv
bench/testbench.sv
